>>> rtl/rdq_pkg.sv
// Shared constants, codes and types for the ring deque with remove.
package rdq_pkg;

  localparam int unsigned Depth = 16;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned WordW = 32;
  localparam int unsigned IdxW  = 4;
  localparam int unsigned ReqW  = 3;
  localparam int unsigned StatW = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_REMOVE     = 3'd4
  } req_e;

  typedef enum logic [StatW-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT_RD,
    ST_SHIFT_WR
  } state_e;

  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [WordW-1:0] word_t;

endpackage

>>> rtl/ring_deque_with_remove.sv
// Top level of the ring deque with remove: pointers, control sequencer and entry memory.
//
//   channel   direction  handshake               fields
//   request   in         start_i / busy_o        req_type_i, value_i, index_i
//   result    out        done_o (one cycle)      data_out_o, status_o, count_after_o
//
// A push, a rejected request or an unknown request gives its result in the cycle after
// it is accepted, and busy_o stays low, so one of these can be accepted every cycle.
// A pop raises busy_o while the sequencer waits in ST_READ for the entry memory, which has
// a registered read port; the read word then goes out through the registered result.
// A remove at logical index i of a deque holding n words keeps busy_o high through ST_READ,
// then through ST_SHIFT_RD and ST_SHIFT_WR for each of the n - 1 - i words behind it, which
// move one place toward the front, and a last ST_SHIFT_RD; its result shows as busy_o falls.
// Reset clears the pointers and the count; the entry memory is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module ring_deque_with_remove (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [rdq_pkg::ReqW-1:0]  req_type_i,
  input  logic [rdq_pkg::WordW-1:0] value_i,
  input  logic [rdq_pkg::IdxW-1:0]  index_i,
  output logic                      done_o,
  output logic [rdq_pkg::WordW-1:0] data_out_o,
  output logic [rdq_pkg::StatW-1:0] status_o,
  output logic [rdq_pkg::CntW-1:0]  count_after_o
);

  rdq_pkg::state_e  state_q, state_d;
  rdq_pkg::req_e    op_q, op_d;
  rdq_pkg::ptr_t    front_q, front_d;
  rdq_pkg::ptr_t    back_q, back_d;
  rdq_pkg::cnt_t    count_q, count_d;
  rdq_pkg::cnt_t    cursor_q, cursor_d;
  rdq_pkg::word_t   hold_q, hold_d;
  logic             done_q, done_d;
  rdq_pkg::word_t   data_q, data_d;
  rdq_pkg::status_e status_q, status_d;

  rdq_pkg::word_t   mem_q [rdq_pkg::Depth];
  rdq_pkg::word_t   rdata_q;
  logic             mem_we;
  rdq_pkg::ptr_t    mem_waddr;
  rdq_pkg::word_t   mem_wdata;
  rdq_pkg::ptr_t    mem_raddr;

  logic             accept;
  logic             is_full;
  logic             is_empty;
  rdq_pkg::cnt_t    cursor_nxt;

  assign accept     = start_i && (state_q == rdq_pkg::ST_IDLE);
  assign is_full    = (count_q == rdq_pkg::CntW'(rdq_pkg::Depth));
  assign is_empty   = (count_q == '0);
  assign cursor_nxt = cursor_q + rdq_pkg::CntW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rdq_pkg::ST_IDLE;
      front_q  <= '0;
      back_q   <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    cursor_q <= cursor_d;
    hold_q   <= hold_d;
    data_q   <= data_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    hold_d    = hold_q;
    done_d    = 1'b0;
    data_d    = '0;
    status_d  = rdq_pkg::STAT_DONE;
    mem_we    = 1'b0;
    mem_waddr = back_q;
    mem_wdata = value_i;
    mem_raddr = front_q;

    case (state_q)
      rdq_pkg::ST_IDLE: begin
        if (accept) begin
          op_d   = rdq_pkg::req_e'(req_type_i);
          done_d = 1'b1;
          case (rdq_pkg::req_e'(req_type_i))
            rdq_pkg::REQ_PUSH_BACK: begin
              if (is_full) begin
                status_d = rdq_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_q;
                back_d    = back_q + rdq_pkg::PtrW'(1);
                count_d   = count_q + rdq_pkg::CntW'(1);
              end
            end
            rdq_pkg::REQ_PUSH_FRONT: begin
              if (is_full) begin
                status_d = rdq_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = front_q - rdq_pkg::PtrW'(1);
                front_d   = front_q - rdq_pkg::PtrW'(1);
                count_d   = count_q + rdq_pkg::CntW'(1);
              end
            end
            rdq_pkg::REQ_POP_BACK: begin
              if (is_empty) begin
                status_d = rdq_pkg::STAT_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = back_q - rdq_pkg::PtrW'(1);
                back_d    = back_q - rdq_pkg::PtrW'(1);
                count_d   = count_q - rdq_pkg::CntW'(1);
                state_d   = rdq_pkg::ST_READ;
              end
            end
            rdq_pkg::REQ_POP_FRONT: begin
              if (is_empty) begin
                status_d = rdq_pkg::STAT_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = front_q;
                front_d   = front_q + rdq_pkg::PtrW'(1);
                count_d   = count_q - rdq_pkg::CntW'(1);
                state_d   = rdq_pkg::ST_READ;
              end
            end
            rdq_pkg::REQ_REMOVE: begin
              if (rdq_pkg::CntW'(index_i) >= count_q) begin
                status_d = rdq_pkg::STAT_EMPTY;
              end else begin
                done_d    = 1'b0;
                mem_raddr = front_q + rdq_pkg::PtrW'(index_i);
                cursor_d  = rdq_pkg::CntW'(index_i);
                state_d   = rdq_pkg::ST_READ;
              end
            end
            default: begin
              status_d = rdq_pkg::STAT_DONE;
            end
          endcase
        end
      end
      rdq_pkg::ST_READ: begin
        if (op_q == rdq_pkg::REQ_REMOVE) begin
          hold_d  = rdata_q;
          state_d = rdq_pkg::ST_SHIFT_RD;
        end else begin
          done_d  = 1'b1;
          data_d  = rdata_q;
          state_d = rdq_pkg::ST_IDLE;
        end
      end
      rdq_pkg::ST_SHIFT_RD: begin
        if (cursor_nxt < count_q) begin
          mem_raddr = front_q + cursor_nxt[rdq_pkg::PtrW-1:0];
          state_d   = rdq_pkg::ST_SHIFT_WR;
        end else begin
          back_d  = back_q - rdq_pkg::PtrW'(1);
          count_d = count_q - rdq_pkg::CntW'(1);
          done_d  = 1'b1;
          data_d  = hold_q;
          state_d = rdq_pkg::ST_IDLE;
        end
      end
      rdq_pkg::ST_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = front_q + cursor_q[rdq_pkg::PtrW-1:0];
        mem_wdata = rdata_q;
        cursor_d  = cursor_nxt;
        state_d   = rdq_pkg::ST_SHIFT_RD;
      end
      default: begin
        state_d = rdq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o        = (state_q != rdq_pkg::ST_IDLE);
  assign done_o        = done_q;
  assign data_out_o    = data_q;
  assign status_o      = status_q;
  assign count_after_o = count_q;

  // The back pointer always sits count words past the front pointer.
  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_q == front_q + count_q[rdq_pkg::PtrW-1:0])
    else $error("back pointer does not match front pointer plus count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rdq_pkg::CntW'(rdq_pkg::Depth))
    else $error("entry count exceeds the depth");

  // Every multi-cycle request ends with exactly one result word.
  a_end_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("sequencer returned to idle without a result");

  a_pop_waits_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_empty && (req_type_i == rdq_pkg::REQ_POP_BACK ||
     req_type_i == rdq_pkg::REQ_POP_FRONT)) |=> (busy_o && !done_o))
    else $error("pop did not wait for the memory read");

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == rdq_pkg::ST_IDLE) |-> !is_full)
    else $error("push written into a full deque");

endmodule

>>> tb/sv/ring_deque_with_remove_tb.sv
// Self-checking testbench for the ring deque with remove: directed and random request streams.
`timescale 1ns / 1ps

module ring_deque_with_remove_tb;

  localparam logic [rdq_pkg::ReqW-1:0] ReqFirstUnused = 3'd5;
  localparam logic [rdq_pkg::ReqW-1:0] ReqLast        = 3'd7;
  localparam int unsigned              StallLimit     = 1000;
  localparam int unsigned              DrainCycles    = 40;
  localparam int unsigned              ReportLimit    = 10;
  localparam int unsigned              RandomWords    = 600;

  typedef struct packed {
    rdq_pkg::word_t            data;
    logic [rdq_pkg::StatW-1:0] status;
    rdq_pkg::cnt_t             count;
  } result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic [rdq_pkg::ReqW-1:0]    req_type_i;
  logic [rdq_pkg::WordW-1:0]   value_i;
  logic [rdq_pkg::IdxW-1:0]    index_i;
  logic                        done_o;
  logic [rdq_pkg::WordW-1:0]   data_out_o;
  logic [rdq_pkg::StatW-1:0]   status_o;
  logic [rdq_pkg::CntW-1:0]    count_after_o;

  rdq_pkg::word_t ring_slots [rdq_pkg::Depth];
  rdq_pkg::ptr_t  front_slot;
  rdq_pkg::ptr_t  back_slot;
  rdq_pkg::cnt_t  held_words;
  result_t        pending_results [$];
  int             mismatch_count;
  bit             no_gaps;

  ring_deque_with_remove u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .req_type_i    (req_type_i),
    .value_i       (value_i),
    .index_i       (index_i),
    .done_o        (done_o),
    .data_out_o    (data_out_o),
    .status_o      (status_o),
    .count_after_o (count_after_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t model_request(logic [rdq_pkg::ReqW-1:0] req,
                                            rdq_pkg::word_t val,
                                            logic [rdq_pkg::IdxW-1:0] idx);
    result_t       r;
    rdq_pkg::ptr_t cur;
    rdq_pkg::ptr_t nxt;
    r.data   = '0;
    r.status = rdq_pkg::STAT_DONE;
    case (req)
      rdq_pkg::REQ_PUSH_BACK: begin
        if (held_words == rdq_pkg::cnt_t'(rdq_pkg::Depth)) begin
          r.status = rdq_pkg::STAT_FULL;
        end else begin
          ring_slots[back_slot] = val;
          back_slot = back_slot + rdq_pkg::ptr_t'(1);
          held_words = held_words + rdq_pkg::cnt_t'(1);
        end
      end
      rdq_pkg::REQ_PUSH_FRONT: begin
        if (held_words == rdq_pkg::cnt_t'(rdq_pkg::Depth)) begin
          r.status = rdq_pkg::STAT_FULL;
        end else begin
          front_slot = front_slot - rdq_pkg::ptr_t'(1);
          ring_slots[front_slot] = val;
          held_words = held_words + rdq_pkg::cnt_t'(1);
        end
      end
      rdq_pkg::REQ_POP_BACK: begin
        if (held_words == '0) begin
          r.status = rdq_pkg::STAT_EMPTY;
        end else begin
          back_slot = back_slot - rdq_pkg::ptr_t'(1);
          r.data = ring_slots[back_slot];
          held_words = held_words - rdq_pkg::cnt_t'(1);
        end
      end
      rdq_pkg::REQ_POP_FRONT: begin
        if (held_words == '0) begin
          r.status = rdq_pkg::STAT_EMPTY;
        end else begin
          r.data = ring_slots[front_slot];
          front_slot = front_slot + rdq_pkg::ptr_t'(1);
          held_words = held_words - rdq_pkg::cnt_t'(1);
        end
      end
      rdq_pkg::REQ_REMOVE: begin
        if (rdq_pkg::cnt_t'(idx) >= held_words) begin
          r.status = rdq_pkg::STAT_EMPTY;
        end else begin
          cur = front_slot + rdq_pkg::ptr_t'(idx);
          r.data = ring_slots[cur];
          for (int i = int'(idx); i + 1 < int'(held_words); i++) begin
            cur = front_slot + rdq_pkg::ptr_t'(i);
            nxt = cur + rdq_pkg::ptr_t'(1);
            ring_slots[cur] = ring_slots[nxt];
          end
          back_slot = back_slot - rdq_pkg::ptr_t'(1);
          held_words = held_words - rdq_pkg::cnt_t'(1);
        end
      end
      default: begin
      end
    endcase
    r.count = held_words;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatch_count < ReportLimit) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  task automatic send_word(logic [rdq_pkg::ReqW-1:0] req, rdq_pkg::word_t val,
                           logic [rdq_pkg::IdxW-1:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
    @(negedge clk_i);
    start_i    <= 1'b1;
    req_type_i <= req;
    value_i    <= val;
    index_i    <= idx;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(model_request(req, val, idx));
  endtask

  task automatic test_empty_requests();
    send_word(rdq_pkg::REQ_POP_BACK, $urandom(), rdq_pkg::IdxW'($urandom()));
    send_word(rdq_pkg::REQ_POP_FRONT, $urandom(), rdq_pkg::IdxW'($urandom()));
    send_word(rdq_pkg::REQ_REMOVE, $urandom(), '0);
  endtask

  task automatic test_fill_to_full();
    rdq_pkg::word_t val;
    for (int k = 0; k < rdq_pkg::Depth; k++) begin
      case (k % 4)
        0: val = '0;
        1: val = '1;
        2: val = 32'h8000_0001;
        default: val = $urandom();
      endcase
      send_word((k % 2 == 0) ? rdq_pkg::REQ_PUSH_BACK : rdq_pkg::REQ_PUSH_FRONT, val,
                rdq_pkg::IdxW'($urandom()));
    end
    send_word(rdq_pkg::REQ_PUSH_BACK, '1, '1);
    send_word(rdq_pkg::REQ_PUSH_FRONT, '0, '0);
  endtask

  task automatic test_remove_positions();
    send_word(rdq_pkg::REQ_REMOVE, '0, 4'd15);
    send_word(rdq_pkg::REQ_REMOVE, '1, 4'd0);
    send_word(rdq_pkg::REQ_REMOVE, $urandom(), 4'd6);
    send_word(rdq_pkg::REQ_REMOVE, $urandom(), 4'd15);
  endtask

  task automatic test_pops();
    send_word(rdq_pkg::REQ_POP_BACK, $urandom(), rdq_pkg::IdxW'($urandom()));
    send_word(rdq_pkg::REQ_POP_FRONT, $urandom(), rdq_pkg::IdxW'($urandom()));
  endtask

  task automatic test_unknown_requests();
    for (int r = int'(ReqFirstUnused); r <= int'(ReqLast); r++) begin
      send_word(r[rdq_pkg::ReqW-1:0], '1, '1);
    end
  endtask

  task automatic test_random_traffic(int n);
    int                       push_pct;
    int                       pick;
    logic [rdq_pkg::ReqW-1:0] req;
    logic [rdq_pkg::IdxW-1:0] idx;
    push_pct = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 20;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
        no_gaps = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        req = rdq_pkg::ReqW'($urandom_range(int'(ReqFirstUnused), int'(ReqLast)));
      end else if (pick < 18) begin
        req = rdq_pkg::REQ_REMOVE;
      end else if ($urandom_range(0, 99) < push_pct) begin
        req = $urandom_range(0, 1) ? rdq_pkg::REQ_PUSH_FRONT : rdq_pkg::REQ_PUSH_BACK;
      end else begin
        req = $urandom_range(0, 1) ? rdq_pkg::REQ_POP_FRONT : rdq_pkg::REQ_POP_BACK;
      end
      if (req == rdq_pkg::REQ_REMOVE && held_words != '0 && $urandom_range(0, 9) != 0) begin
        idx = rdq_pkg::IdxW'($urandom_range(0, int'(held_words) - 1));
      end else begin
        idx = rdq_pkg::IdxW'($urandom());
      end
      send_word(req, $urandom(), idx);
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result data %h status %0d count %0d",
                                data_out_o, status_o, count_after_o));
      end else begin
        want = pending_results.pop_front();
        if (data_out_o !== want.data || status_o !== want.status ||
            count_after_o !== want.count) begin
          note_mismatch($sformatf("expected data %h status %0d count %0d, got %h %0d %0d",
                                  want.data, want.status, want.count,
                                  data_out_o, status_o, count_after_o));
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    req_type_i = '0;
    value_i    = '0;
    index_i    = '0;
    no_gaps    = 1'b0;
    mismatch_count = 0;
    for (int i = 0; i < rdq_pkg::Depth; i++) begin
      ring_slots[i] = '0;
    end
    front_slot = '0;
    back_slot  = '0;
    held_words = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_requests();
    test_fill_to_full();
    test_remove_positions();
    test_pops();
    test_unknown_requests();
    test_random_traffic(RandomWords);

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (pending_results.size() != 0) begin
      note_mismatch("results still pending at the end");
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
